### design/hcb_pkg.sv
// ----------------------------------------------------------------------------
// hcb_pkg
// Shared types and constants of the Huffman code builder and codec.
// ----------------------------------------------------------------------------
package hcb_pkg;

  localparam int SymCount    = 256;
  localparam int SymW        = 8;
  localparam int NodeTotal   = 2 * SymCount - 1;
  localparam int NodeW       = $clog2(NodeTotal);
  localparam int CountBits   = 16;
  localparam int WeightBits  = 24;
  localparam int MaxCodeBits = 32;
  localparam int LenW        = 6;

  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};
  localparam logic [LenW-1:0]      LenMax   = LenW'(MaxCodeBits);
  localparam logic [LenW-1:0]      LenOver  = LenW'(MaxCodeBits + 1);

  localparam logic KindCode   = 1'b0;
  localparam logic KindSymbol = 1'b1;

  typedef enum logic [1:0] {
    REQ_COUNT  = 2'd0,
    REQ_ENCODE = 2'd1,
    REQ_DECODE = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    MODE_EMPTY  = 2'd0,
    MODE_SINGLE = 2'd1,
    MODE_TREE   = 2'd2
  } dec_mode_e;

  // Tree node: leaves hold the histogram count as their weight.
  typedef struct packed {
    logic                  live;
    logic [WeightBits-1:0] weight;
    logic [NodeW-1:0]      left;
    logic [NodeW-1:0]      right;
  } tree_ent_t;

  // Code of a node: depth saturates at one past the longest legal code.
  typedef struct packed {
    logic [LenW-1:0]        dep;
    logic [MaxCodeBits-1:0] val;
  } code_ent_t;

  typedef struct packed {
    logic             en;
    logic [NodeW-1:0] addr;
    tree_ent_t        data;
  } tree_wr_t;

  typedef struct packed {
    logic             en;
    logic [NodeW-1:0] addr;
    code_ent_t        data;
  } code_wr_t;

endpackage

### design/hcb_tree_mem.sv
// ----------------------------------------------------------------------------
// hcb_tree_mem
// Node memory: histogram in the leaves, merge tree in the internal nodes.
// ----------------------------------------------------------------------------
module hcb_tree_mem import hcb_pkg::*; (
  input  logic             clk_i,
  input  tree_wr_t         wr_i,
  input  logic [NodeW-1:0] rd_addr_i,
  output tree_ent_t        rd_data_o
);

  tree_ent_t mem_q [NodeTotal];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

### design/hcb_code_mem.sv
// ----------------------------------------------------------------------------
// hcb_code_mem
// Code memory: code value and depth of every node; leaves form the table.
// ----------------------------------------------------------------------------
module hcb_code_mem import hcb_pkg::*; (
  input  logic             clk_i,
  input  code_wr_t         wr_i,
  input  logic [NodeW-1:0] rd_addr_i,
  output code_ent_t        rd_data_o
);

  code_ent_t mem_q [NodeTotal];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

### design/huffman_code_builder_codec_top.sv
// ----------------------------------------------------------------------------
// huffman_code_builder_codec_top
// Byte-alphabet Huffman engine: histogram, code build, encode and decode.
// ----------------------------------------------------------------------------
// One request at a time is processed around two node memories, each with one
// read and one write port. After reset a pass clears the histogram and the
// code table before the first request is taken. A count request reads and
// writes back its histogram entry, after a histogram clear when it is the
// first count after a build. An encode request reads the code table and a
// decode request in tree mode reads one tree node; a result waits in the
// response step while the result register is still occupied. A count request
// with tlast set then builds the code: a pass loads the leaves, then for each
// of the N-1 merges a scan over all nodes created so far is followed by three
// writes, then three steps per internal node push codes down the tree. The
// sequencing is set by the one read and one write port of the node memories.
module huffman_code_builder_codec_top import hcb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // req_type[1:0], symbol[9:2], code_bit[10]
  input  logic        s_axis_tlast,  // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // code_value[31:0], code_length[37:32],
                                     // decoded_symbol[45:38]
  output logic        m_axis_tuser   // result_kind
);

  typedef enum logic [19:0] {
    ST_IDLE     = 20'h00001,
    ST_CLR      = 20'h00002,
    ST_CNT_RD   = 20'h00004,
    ST_CNT_WR   = 20'h00008,
    ST_ENC_RD   = 20'h00010,
    ST_ENC_EV   = 20'h00020,
    ST_DEC_RD   = 20'h00040,
    ST_DEC_EV   = 20'h00080,
    ST_RESP     = 20'h00100,
    ST_INIT_RD  = 20'h00200,
    ST_INIT_WR  = 20'h00400,
    ST_INIT_END = 20'h00800,
    ST_SCAN     = 20'h01000,
    ST_WR_A     = 20'h02000,
    ST_WR_B     = 20'h04000,
    ST_WR_N     = 20'h08000,
    ST_TR_ROOT  = 20'h10000,
    ST_TR_RD    = 20'h20000,
    ST_TR_WL    = 20'h40000,
    ST_TR_WR    = 20'h80000
  } state_e;

  state_e    state_q, state_d;
  logic [SymW-1:0]  sym_q, sym_d;
  logic             bit_q, bit_d;
  logic             last_q, last_d;
  logic             built_q, built_d;
  logic             clr_code_q, clr_code_d;
  logic [NodeW-1:0] idx_q, idx_d;
  logic [NodeW-1:0] next_q, next_d;
  logic [NodeW-1:0] active_q, active_d;
  logic [SymW-1:0]  single_q, single_d;
  dec_mode_e        mode_q, mode_d;
  logic [NodeW-1:0] root_q, root_d;
  logic [NodeW-1:0] cur_q, cur_d;
  logic [LenW-1:0]  dlen_q, dlen_d;
  logic             sv_q, sv_d;
  logic [NodeW-1:0] sidx_q, sidx_d;
  logic             h1_q, h1_d, h2_q, h2_d;
  logic [NodeW-1:0] a_q, a_d, b_q, b_d;
  tree_ent_t        ea_q, ea_d, eb_q, eb_d;

  logic                   res_kind_q, res_kind_d;
  logic [MaxCodeBits-1:0] res_val_q, res_val_d;
  logic [LenW-1:0]        res_len_q, res_len_d;
  logic [SymW-1:0]        res_sym_q, res_sym_d;
  logic                   m_valid_q, m_valid_d;
  logic                   m_kind_q;
  logic [MaxCodeBits-1:0] m_val_q;
  logic [LenW-1:0]        m_len_q;
  logic [SymW-1:0]        m_sym_q;
  logic                   m_load;

  tree_wr_t         tree_wr;
  code_wr_t         code_wr;
  logic [NodeW-1:0] tree_rd_addr, code_rd_addr;
  tree_ent_t        tree_rd;
  code_ent_t        code_rd;

  logic                  accept;
  req_e                  in_req;
  logic [CountBits-1:0]  cnt;
  logic [WeightBits:0]   wsum;
  logic [NodeW-1:0]      child;
  logic [LenW-1:0]       ndep;
  logic [LenW-1:0]       dlen_inc;

  hcb_tree_mem u_tree_mem (
    .clk_i    (clk_i),
    .wr_i     (tree_wr),
    .rd_addr_i(tree_rd_addr),
    .rd_data_o(tree_rd)
  );

  hcb_code_mem u_code_mem (
    .clk_i    (clk_i),
    .wr_i     (code_wr),
    .rd_addr_i(code_rd_addr),
    .rd_data_o(code_rd)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_req        = req_e'(s_axis_tdata[1:0]);
  assign cnt           = tree_rd.weight[CountBits-1:0];
  assign wsum          = {1'b0, ea_q.weight} + {1'b0, eb_q.weight};
  assign child         = bit_q ? tree_rd.right : tree_rd.left;
  assign ndep          = (code_rd.dep >= LenOver) ? LenOver : code_rd.dep + 1'b1;
  assign dlen_inc      = dlen_q + 1'b1;
  assign m_load        = (state_q == ST_RESP) && (!m_valid_q || m_axis_tready);

  always_comb begin
    state_d    = state_q;
    sym_d      = sym_q;
    bit_d      = bit_q;
    last_d     = last_q;
    built_d    = built_q;
    clr_code_d = clr_code_q;
    idx_d      = idx_q;
    next_d     = next_q;
    active_d   = active_q;
    single_d   = single_q;
    mode_d     = mode_q;
    root_d     = root_q;
    cur_d      = cur_q;
    dlen_d     = dlen_q;
    sv_d       = 1'b0;
    sidx_d     = sidx_q;
    h1_d       = h1_q;
    h2_d       = h2_q;
    a_d        = a_q;
    b_d        = b_q;
    ea_d       = ea_q;
    eb_d       = eb_q;
    res_kind_d = res_kind_q;
    res_val_d  = res_val_q;
    res_len_d  = res_len_q;
    res_sym_d  = res_sym_q;
    tree_wr    = '0;
    code_wr    = '0;
    tree_rd_addr = idx_q;
    code_rd_addr = idx_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          sym_d  = s_axis_tdata[9:2];
          bit_d  = s_axis_tdata[10];
          last_d = s_axis_tlast;
          case (in_req)
            REQ_COUNT: begin
              if (built_q) begin
                idx_d      = '0;
                clr_code_d = 1'b0;
                state_d    = ST_CLR;
              end else begin
                state_d = ST_CNT_RD;
              end
            end
            REQ_ENCODE: state_d = ST_ENC_RD;
            REQ_DECODE: begin
              if (mode_q == MODE_TREE) begin
                state_d = ST_DEC_RD;
              end else if (mode_q == MODE_SINGLE && dlen_q == '0 &&
                           !s_axis_tdata[10]) begin
                res_kind_d = KindSymbol;
                res_val_d  = '0;
                res_len_d  = '0;
                res_sym_d  = single_q;
                state_d    = ST_RESP;
              end else begin
                // No code can match: just count bits until the prefix is dropped.
                dlen_d = (dlen_inc == LenMax) ? '0 : dlen_inc;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CLR: begin
        tree_wr.en   = 1'b1;
        tree_wr.addr = idx_q;
        code_wr.en   = clr_code_q;
        code_wr.addr = idx_q;
        built_d      = 1'b0;
        idx_d        = idx_q + 1'b1;
        if (idx_q == NodeW'(SymCount - 1)) begin
          state_d = clr_code_q ? ST_IDLE : ST_CNT_RD;
        end
      end
      ST_CNT_RD: begin
        tree_rd_addr = NodeW'(sym_q);
        state_d      = ST_CNT_WR;
      end
      ST_CNT_WR: begin
        tree_wr.en          = 1'b1;
        tree_wr.addr        = NodeW'(sym_q);
        tree_wr.data.weight = WeightBits'((cnt == CountMax) ? cnt : cnt + 1'b1);
        if (last_q) begin
          idx_d    = '0;
          active_d = '0;
          state_d  = ST_INIT_RD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_ENC_RD: begin
        code_rd_addr = NodeW'(sym_q);
        state_d      = ST_ENC_EV;
      end
      ST_ENC_EV: begin
        res_kind_d = KindCode;
        res_sym_d  = '0;
        if (code_rd.dep <= LenMax) begin
          res_val_d = code_rd.val;
          res_len_d = code_rd.dep;
        end else begin
          res_val_d = '0;
          res_len_d = '0;
        end
        state_d = ST_RESP;
      end
      ST_DEC_RD: begin
        tree_rd_addr = cur_q;
        state_d      = ST_DEC_EV;
      end
      ST_DEC_EV: begin
        state_d = ST_IDLE;
        if (child < NodeW'(SymCount)) begin
          res_kind_d = KindSymbol;
          res_val_d  = '0;
          res_len_d  = '0;
          res_sym_d  = child[SymW-1:0];
          cur_d      = root_q;
          dlen_d     = '0;
          state_d    = ST_RESP;
        end else if (dlen_inc == LenMax) begin
          cur_d  = root_q;
          dlen_d = '0;
        end else begin
          cur_d  = child;
          dlen_d = dlen_inc;
        end
      end
      ST_RESP: begin
        if (m_load) begin
          state_d = ST_IDLE;
        end
      end
      ST_INIT_RD: begin
        state_d = ST_INIT_WR;
      end
      ST_INIT_WR: begin
        tree_wr.en          = 1'b1;
        tree_wr.addr        = idx_q;
        tree_wr.data.weight = tree_rd.weight;
        tree_wr.data.live   = (tree_rd.weight != '0);
        code_wr.en          = 1'b1;
        code_wr.addr        = idx_q;
        if (tree_rd.weight != '0) begin
          active_d = active_q + 1'b1;
          single_d = idx_q[SymW-1:0];
        end
        idx_d   = idx_q + 1'b1;
        state_d = (idx_q == NodeW'(SymCount - 1)) ? ST_INIT_END : ST_INIT_RD;
      end
      ST_INIT_END: begin
        built_d = 1'b1;
        dlen_d  = '0;
        if (active_q == '0) begin
          mode_d  = MODE_EMPTY;
          state_d = ST_IDLE;
        end else if (active_q == NodeW'(1)) begin
          code_wr.en       = 1'b1;
          code_wr.addr     = NodeW'(single_q);
          code_wr.data.dep = LenW'(1);
          mode_d           = MODE_SINGLE;
          state_d          = ST_IDLE;
        end else begin
          next_d  = NodeW'(SymCount);
          idx_d   = '0;
          h1_d    = 1'b0;
          h2_d    = 1'b0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx_q != next_q) begin
          sv_d   = 1'b1;
          sidx_d = idx_q;
          idx_d  = idx_q + 1'b1;
        end
        // Strict compares keep the lower index on equal weights.
        if (sv_q && tree_rd.live) begin
          if (!h1_q || tree_rd.weight < ea_q.weight) begin
            h2_d = h1_q;
            b_d  = a_q;
            eb_d = ea_q;
            h1_d = 1'b1;
            a_d  = sidx_q;
            ea_d = tree_rd;
          end else if (!h2_q || tree_rd.weight < eb_q.weight) begin
            h2_d = 1'b1;
            b_d  = sidx_q;
            eb_d = tree_rd;
          end
        end
        if (idx_q == next_q && !sv_q) begin
          state_d = ST_WR_A;
        end
      end
      ST_WR_A: begin
        tree_wr.en        = 1'b1;
        tree_wr.addr      = a_q;
        tree_wr.data      = ea_q;
        tree_wr.data.live = 1'b0;
        state_d           = ST_WR_B;
      end
      ST_WR_B: begin
        tree_wr.en        = 1'b1;
        tree_wr.addr      = b_q;
        tree_wr.data      = eb_q;
        tree_wr.data.live = 1'b0;
        state_d           = ST_WR_N;
      end
      ST_WR_N: begin
        tree_wr.en          = 1'b1;
        tree_wr.addr        = next_q;
        tree_wr.data.live   = 1'b1;
        tree_wr.data.weight = wsum[WeightBits] ? {WeightBits{1'b1}} :
                                                 wsum[WeightBits-1:0];
        tree_wr.data.left   = a_q;
        tree_wr.data.right  = b_q;
        next_d   = next_q + 1'b1;
        active_d = active_q - 1'b1;
        idx_d    = '0;
        h1_d     = 1'b0;
        h2_d     = 1'b0;
        if (active_q == NodeW'(2)) begin
          root_d  = next_q;
          state_d = ST_TR_ROOT;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_TR_ROOT: begin
        code_wr.en   = 1'b1;
        code_wr.addr = root_q;
        idx_d        = root_q;
        mode_d       = MODE_TREE;
        cur_d        = root_q;
        state_d      = ST_TR_RD;
      end
      ST_TR_RD: begin
        state_d = ST_TR_WL;
      end
      ST_TR_WL: begin
        code_wr.en       = 1'b1;
        code_wr.addr     = tree_rd.left;
        code_wr.data.dep = ndep;
        code_wr.data.val = {code_rd.val[MaxCodeBits-2:0], 1'b0};
        state_d          = ST_TR_WR;
      end
      ST_TR_WR: begin
        code_wr.en       = 1'b1;
        code_wr.addr     = tree_rd.right;
        code_wr.data.dep = ndep;
        code_wr.data.val = {code_rd.val[MaxCodeBits-2:0], 1'b1};
        if (idx_q == NodeW'(SymCount)) begin
          state_d = ST_IDLE;
        end else begin
          idx_d   = idx_q - 1'b1;
          state_d = ST_TR_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q && !m_axis_tready;
    if (m_load) begin
      m_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLR;
      built_q    <= 1'b0;
      clr_code_q <= 1'b1;
      idx_q      <= '0;
      next_q     <= '0;
      active_q   <= '0;
      mode_q     <= MODE_EMPTY;
      root_q     <= '0;
      cur_q      <= '0;
      dlen_q     <= '0;
      sv_q       <= 1'b0;
      h1_q       <= 1'b0;
      h2_q       <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      built_q    <= built_d;
      clr_code_q <= clr_code_d;
      idx_q      <= idx_d;
      next_q     <= next_d;
      active_q   <= active_d;
      mode_q     <= mode_d;
      root_q     <= root_d;
      cur_q      <= cur_d;
      dlen_q     <= dlen_d;
      sv_q       <= sv_d;
      h1_q       <= h1_d;
      h2_q       <= h2_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q      <= sym_d;
    bit_q      <= bit_d;
    last_q     <= last_d;
    single_q   <= single_d;
    sidx_q     <= sidx_d;
    a_q        <= a_d;
    b_q        <= b_d;
    ea_q       <= ea_d;
    eb_q       <= eb_d;
    res_kind_q <= res_kind_d;
    res_val_q  <= res_val_d;
    res_len_q  <= res_len_d;
    res_sym_q  <= res_sym_d;
    if (m_load) begin
      m_kind_q <= res_kind_q;
      m_val_q  <= res_val_q;
      m_len_q  <= res_len_q;
      m_sym_q  <= res_sym_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_kind_q;
  assign m_axis_tdata  = {2'b00, m_sym_q, m_len_q, m_val_q};

  ap_dlen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dlen_q < LenMax)
    else $error("decode prefix length reached the maximum code length");

  ap_merge_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WR_N) |-> (h1_q && h2_q && a_q != b_q))
    else $error("merge without two distinct live nodes");

  ap_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_RESP))
    else $error("result appeared without a response step");

endmodule
